@@ hw/rtl/dtc_pkg.sv @@
// dtc_pkg: opcodes, register indexes and prescaler tap selection for the
// divider and timer counter block; no dependencies

package dtc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned SELECT_W = 2;
   localparam int unsigned TAP_W    = 3;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 32;
   localparam int unsigned REG_IDX_W = 2;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [OPCODE_W-1:0] opcode_field_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_TICK          = 2'd0,
      OP_WRITE_TIMER   = 2'd1,
      OP_WRITE_DIVIDER = 2'd2
   } opcode_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_RELOAD_VALUE = 2'd0,
      REG_TIMER_ENABLE = 2'd1,
      REG_CLOCK_SELECT = 2'd2
   } reg_index_type;

   localparam logic [BYTE_W-3:0] PRESCALE_LOW_ZERO = '0;

   // prescaler bit watched for the falling edge
   function automatic logic [TAP_W-1:0] tap_index(input logic [SELECT_W-1:0] sel);
      logic [TAP_W-1:0] idx;
      case (sel)
         2'd0:    idx = 3'd7;
         2'd1:    idx = 3'd1;
         2'd2:    idx = 3'd3;
         default: idx = 3'd5;
      endcase
      return idx;
   endfunction

endpackage

@@ hw/rtl/dtc_req_if.sv @@
// dtc_req_if: input item channel (valid, ready, opcode, write_value)
// depends on dtc_pkg

interface dtc_req_if;
   import dtc_pkg::*;

   logic             valid;
   logic             ready;
   opcode_field_type opcode;
   byte_type         write_value;

   modport source (output valid, output opcode, output write_value, input ready);
   modport sink   (input valid, input opcode, input write_value, output ready);
endinterface

@@ hw/rtl/dtc_rsp_if.sv @@
// dtc_rsp_if: result item channel (valid, ready, divider, timer, interrupt)
// depends on dtc_pkg

interface dtc_rsp_if;
   import dtc_pkg::*;

   logic     valid;
   logic     ready;
   byte_type divider_value;
   byte_type timer_value;
   logic     timer_interrupt;

   modport source (output valid, output divider_value, output timer_value,
                   output timer_interrupt, input ready);
   modport sink   (input valid, input divider_value, input timer_value,
                   input timer_interrupt, output ready);
endinterface

@@ hw/rtl/divider_and_timer_counter_top.sv @@
// divider_and_timer_counter_top: prescaler, divider register and timer counter
// depends on dtc_pkg, dtc_req_if, dtc_rsp_if
//
//   channel   | direction | handshake            | payload
//   req_chan  | in        | valid / ready        | opcode, write_value
//   rsp_chan  | out       | valid / ready        | divider_value, timer_value, timer_interrupt
//   csr_*     | in        | psel, penable, pwrite | reload value, timer_enable, clock_select
//
// one item per cycle while results are taken; a taken item passes the input register,
// then one pass of tick logic into the result register
// synchronous reset clears configuration, counter state and valid flags
// a stalled result holds; the input register still takes an item while it is free

module divider_and_timer_counter_top (
   input  logic                   clock,
   input  logic                   reset,
   dtc_req_if.sink                req_chan,
   dtc_rsp_if.source              rsp_chan,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [dtc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [dtc_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [dtc_pkg::CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);
   import dtc_pkg::*;

   // configuration
   byte_type              reload_value_ff;
   logic                  timer_enable_ff;
   logic [SELECT_W-1:0]   clock_select_ff;
   logic                  csr_write;
   logic [REG_IDX_W-1:0]  csr_index;

   // input register
   logic                  s1_valid_ff;
   opcode_field_type      s1_opcode_ff;
   byte_type              s1_value_ff;

   // block state
   byte_type              prescale_ff, prescale_in;
   byte_type              divider_ff, divider_in;
   byte_type              timer_ff, timer_in;
   logic                  irq_in;

   // result register
   logic                  out_valid_ff;
   byte_type              out_divider_ff;
   byte_type              out_timer_ff;
   logic                  out_irq_ff;

   logic                  advance;
   logic [TAP_W-1:0]      tap;
   byte_type              prescale_next;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_AW-1:CSR_AW-REG_IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_value_ff <= '0;
         timer_enable_ff <= 1'b0;
         clock_select_ff <= '0;
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_RELOAD_VALUE: reload_value_ff <= csr_pwdata[BYTE_W-1:0];
            REG_TIMER_ENABLE: timer_enable_ff <= csr_pwdata[0];
            REG_CLOCK_SELECT: clock_select_ff <= csr_pwdata[SELECT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(csr_index))
         REG_RELOAD_VALUE: csr_prdata = {{(CSR_DW-BYTE_W){1'b0}}, reload_value_ff};
         REG_TIMER_ENABLE: csr_prdata = {{(CSR_DW-1){1'b0}}, timer_enable_ff};
         REG_CLOCK_SELECT: csr_prdata = {{(CSR_DW-SELECT_W){1'b0}}, clock_select_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // pipeline flow
   assign advance        = s1_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~s1_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready & req_chan.valid) begin
         s1_opcode_ff <= req_chan.opcode;
         s1_value_ff  <= req_chan.write_value;
      end
   end

   // tick logic
   assign tap           = tap_index(clock_select_ff);
   assign prescale_next = prescale_ff + 8'd1;

   always_comb begin
      prescale_in = prescale_ff;
      divider_in  = divider_ff;
      timer_in    = timer_ff;
      irq_in      = 1'b0;
      case (opcode_type'(s1_opcode_ff))
         OP_TICK: begin
            prescale_in = prescale_next;
            if (prescale_next[BYTE_W-3:0] == PRESCALE_LOW_ZERO) begin
               divider_in = divider_ff + 8'd1;
            end
            if (prescale_ff[tap] & ~prescale_next[tap] & timer_enable_ff) begin
               if (timer_ff == 8'hff) begin
                  timer_in = reload_value_ff;
                  irq_in   = 1'b1;
               end else begin
                  timer_in = timer_ff + 8'd1;
               end
            end
         end
         OP_WRITE_TIMER:   timer_in   = s1_value_ff;
         OP_WRITE_DIVIDER: divider_in = s1_value_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         divider_ff  <= '0;
         timer_ff    <= '0;
      end else if (advance) begin
         prescale_ff <= prescale_in;
         divider_ff  <= divider_in;
         timer_ff    <= timer_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_divider_ff <= divider_in;
         out_timer_ff   <= timer_in;
         out_irq_ff     <= irq_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.divider_value   = out_divider_ff;
   assign rsp_chan.timer_value     = out_timer_ff;
   assign rsp_chan.timer_interrupt = out_irq_ff;

endmodule

@@ sim/dtc_checker.sv @@
// dtc_checker: follows csr writes and both item channels of the divider and timer
// counter, predicts every result item and compares it field by field
// depends on dtc_pkg, dtc_req_if, dtc_rsp_if

module dtc_checker (
   input  logic                       clock,
   input  logic                       reset,
   dtc_req_if                         req_mon,
   dtc_rsp_if                         rsp_mon,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic                       csr_pready,
   input  logic [dtc_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [dtc_pkg::CSR_DW-1:0] csr_pwdata,
   output int unsigned                mismatch_count,
   output int unsigned                pending_count
);
   import dtc_pkg::*;

   typedef struct packed {
      byte_type divider;
      byte_type timer;
      logic     irq;
   } timer_reading_type;

   localparam byte_type TAP_MASK [4] = '{8'h80, 8'h02, 8'h08, 8'h20};
   localparam int unsigned REPORT_LIMIT = 10;

   byte_type              cfg_modulo;
   logic                  cfg_enable;
   logic [SELECT_W-1:0]   cfg_select;
   byte_type              prescaler;
   byte_type              divider_cnt;
   byte_type              timer_cnt;
   timer_reading_type     expected_readings[$];
   int unsigned           fail_total;

   function automatic timer_reading_type next_reading(input opcode_field_type op,
                                                      input byte_type val);
      timer_reading_type r;
      byte_type          after;
      byte_type          tap;
      r.irq = 1'b0;
      case (op)
         OP_TICK: begin
            after = prescaler + 8'd1;
            tap = TAP_MASK[cfg_select];
            if (after[5:0] == 6'd0) begin
               divider_cnt = divider_cnt + 8'd1;
            end
            if ((prescaler & tap) != 0 && (after & tap) == 0 && cfg_enable) begin
               if (timer_cnt == 8'hff) begin
                  timer_cnt = cfg_modulo;
                  r.irq = 1'b1;
               end else begin
                  timer_cnt = timer_cnt + 8'd1;
               end
            end
            prescaler = after;
         end
         OP_WRITE_TIMER: timer_cnt = val;
         OP_WRITE_DIVIDER: divider_cnt = val;
         default: ;
      endcase
      r.divider = divider_cnt;
      r.timer = timer_cnt;
      return r;
   endfunction

   always @(posedge clock) begin
      timer_reading_type got;
      timer_reading_type want;
      if (reset) begin
         cfg_modulo = '0;
         cfg_enable = 1'b0;
         cfg_select = '0;
         prescaler = '0;
         divider_cnt = '0;
         timer_cnt = '0;
         expected_readings.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_AW-1:2]))
               REG_RELOAD_VALUE: cfg_modulo = csr_pwdata[BYTE_W-1:0];
               REG_TIMER_ENABLE: cfg_enable = csr_pwdata[0];
               REG_CLOCK_SELECT: cfg_select = csr_pwdata[SELECT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.divider = rsp_mon.divider_value;
            got.timer = rsp_mon.timer_value;
            got.irq = rsp_mon.timer_interrupt;
            if (expected_readings.size() == 0) begin
               fail_total++;
               if (fail_total <= REPORT_LIMIT) begin
                  $display("%0t: result item with none expected: div %h timer %h irq %b",
                           $realtime, got.divider, got.timer, got.irq);
               end
            end else begin
               want = expected_readings.pop_front();
               if (got.divider !== want.divider || got.timer !== want.timer ||
                   got.irq !== want.irq) begin
                  fail_total++;
                  if (fail_total <= REPORT_LIMIT) begin
                     $display("%0t: expected div %h timer %h irq %b, got div %h timer %h irq %b",
                              $realtime, want.divider, want.timer, want.irq,
                              got.divider, got.timer, got.irq);
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_readings.push_back(next_reading(req_mon.opcode, req_mon.write_value));
         end
      end
      mismatch_count <= fail_total;
      pending_count <= expected_readings.size();
   end

endmodule

@@ sim/divider_and_timer_counter_top_tb.sv @@
// divider_and_timer_counter_top_tb: clock, reset, csr writes and item stimulus
// for the divider and timer counter; results are judged by dtc_checker
// depends on dtc_pkg, dtc_req_if, dtc_rsp_if, dtc_checker, divider_and_timer_counter_top

module divider_and_timer_counter_top_tb;
   import dtc_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASES = 12;
   localparam int unsigned PHASE_ITEMS = 155;
   localparam opcode_field_type OP_UNUSED = 2'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   int unsigned       gap_pct;
   int unsigned       stall_pct;
   int unsigned       cycle_count;
   int unsigned       mismatch_count;
   int unsigned       pending_count;

   dtc_req_if req_chan ();
   dtc_rsp_if rsp_chan ();

   divider_and_timer_counter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dtc_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_item(input opcode_field_type op, input byte_type val);
      while ($urandom_range(99) < gap_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.write_value <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_random_item();
      int unsigned      roll;
      opcode_field_type op;
      byte_type         val;
      roll = $urandom_range(99);
      val = byte_type'($urandom_range(255));
      if (roll < 78) begin
         op = OP_TICK;
      end else if (roll < 88) begin
         op = OP_WRITE_TIMER;
         // half the time near the top so overflows come often
         if ($urandom_range(1)) val = 8'hff - byte_type'($urandom_range(7));
      end else if (roll < 96) begin
         op = OP_WRITE_DIVIDER;
      end else begin
         op = OP_UNUSED;
      end
      send_item(op, val);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DW-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      gap_pct = 12;
      stall_pct = 50;
      req_chan.valid <= 1'b0;
      req_chan.opcode <= OP_TICK;
      req_chan.write_value <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // timer disabled: writes, unused opcode, ticks that must not count
      send_item(OP_TICK, 8'h00);
      send_item(OP_TICK, 8'hff);
      send_item(OP_UNUSED, 8'haa);
      send_item(OP_WRITE_TIMER, 8'hff);
      send_item(OP_WRITE_TIMER, 8'h00);
      send_item(OP_WRITE_DIVIDER, 8'hff);
      send_item(OP_WRITE_DIVIDER, 8'h55);
      drain();

      // fastest tap, reload from the top value, spare register address ignored
      csr_write(REG_RELOAD_VALUE, 32'h0000_00ff);
      csr_write(REG_TIMER_ENABLE, 32'd1);
      csr_write(REG_CLOCK_SELECT, 32'd1);
      csr_write(REG_SPARE, 32'hffff_ffff);
      send_item(OP_WRITE_TIMER, 8'hff);
      repeat (4) send_item(OP_TICK, byte_type'($urandom_range(255)));
      send_item(OP_UNUSED, 8'h55);
      send_item(OP_WRITE_DIVIDER, 8'h00);
      repeat (4) send_item(OP_TICK, byte_type'($urandom_range(255)));
      send_item(OP_WRITE_TIMER, 8'hfe);
      repeat (6) send_item(OP_TICK, byte_type'($urandom_range(255)));

      for (int unsigned p = 0; p < PHASES; p++) begin
         drain();
         if (p < 4) begin
            gap_pct = 12;
            stall_pct = 50;
         end else if (p < 8) begin
            gap_pct = 50;
            stall_pct = 12;
         end else begin
            gap_pct = 0;
            stall_pct = 0;
         end
         csr_write(REG_RELOAD_VALUE,
                   (p == 0) ? 32'd0 : (p == 1) ? 32'd255 : $urandom_range(255));
         csr_write(REG_TIMER_ENABLE, (p % 3 != 2) ? 32'd1 : 32'd0);
         csr_write(REG_CLOCK_SELECT, p % 4);
         repeat (PHASE_ITEMS) send_random_item();
      end
      drain();

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ divider_and_timer_counter_top.f @@
hw/rtl/dtc_pkg.sv
hw/rtl/dtc_req_if.sv
hw/rtl/dtc_rsp_if.sv
hw/rtl/divider_and_timer_counter_top.sv
sim/dtc_checker.sv
sim/divider_and_timer_counter_top_tb.sv
